// File: hdl/rbp_pkg.sv
// rbp_pkg: shared types, codes and sizes for the refcounted buffer pool
// used by rbp_ctrl, rbp_dp and refcounted_buffer_pool_core; no dependencies
package rbp_pkg;

    // default sizes handed to the top level parameters
    localparam int NUM_ENTRIES_DEF = 64;
    localparam int REF_WIDTH_DEF   = 16;

    // reset entry counts of the two pools
    localparam int POOL0_RESET = 64;
    localparam int POOL1_RESET = 16;

    // field widths on the ports
    localparam int OP_W          = 2;
    localparam int IDX_FIELD_W   = 6;
    localparam int STATUS_W      = 3;
    localparam int REF_FIELD_W   = 16;
    localparam int CNT_FIELD_W   = 7;
    localparam int FAIL_W        = 32;
    localparam int CFG_DATA_W    = 7;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 72;

    // request codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_TAKE    = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_EXHAUSTED = 3'd1,
        STATUS_FREED     = 3'd2,
        STATUS_INVALID   = 3'd3,
        STATUS_SATURATED = 3'd4
    } status_t;

    // configuration register indexes
    typedef enum logic {
        CFG_STREAMING = 1'b0,
        CFG_CONTROL   = 1'b1
    } cfg_idx_t;

    // controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic rd_en;    // read memories for the accepted beat
        logic exec_en;  // update state and load the result register
    } ctrl_cmd_t;

endpackage

// File: hdl/refcounted_buffer_pool_core.sv
// refcounted_buffer_pool_core: top level of the two-pool refcounted buffer manager
// depends on rbp_pkg, rbp_ctrl and rbp_dp
//
//  port group   dir  beat contents
//  s_*          in   request: s_tdata = op, entry_index; s_tuser = pool_select
//  m_*          out  result: status, granted_index, ref_count, in_use, peak in use,
//                    failure count
//  cfg_*        in   register write: cfg_addr 0 streaming_entries, 1 control_entries
//
// each request has a read step for the free stack and reference count memories and
// an update step that writes them and loads the result register; a new request is
// taken once the block is back in idle, even while the last result is still waiting
// a stalled result holds the block in its update cycle until m_tready
// reset gives pool sizes 64 and 16, full free stacks and zero counts at once
module refcounted_buffer_pool_core
#(
    parameter int NUM_ENTRIES = rbp_pkg::NUM_ENTRIES_DEF,
    parameter int REF_WIDTH   = rbp_pkg::REF_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rbp_pkg::IN_TDATA_W-1:0]   s_tdata,  // op[1:0], entry_index[7:2]
    input  logic                             s_tuser,  // pool_select
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[2:0], granted_index[8:3], ref_count[24:9], in_use[31:25],
    // peak_in_use[38:32], fail_count[70:39], zero[71]
    output logic [rbp_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic                             cfg_addr,
    input  logic [rbp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    rbp_pkg::ctrl_cmd_t                cmd;
    logic [rbp_pkg::STATUS_W-1:0]      res_status;
    logic [rbp_pkg::IDX_FIELD_W-1:0]   res_granted;
    logic [rbp_pkg::REF_FIELD_W-1:0]   res_ref_count;
    logic [rbp_pkg::CNT_FIELD_W-1:0]   res_in_use;
    logic [rbp_pkg::CNT_FIELD_W-1:0]   res_peak_in_use;
    logic [rbp_pkg::FAIL_W-1:0]        res_failures;

    // sequencer
    rbp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // pool state and result
    rbp_dp
    #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .REF_WIDTH   (REF_WIDTH)
    )
    u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .in_op           (s_tdata[1:0]),
        .in_pool         (s_tuser),
        .in_index        (s_tdata[7:2]),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .out_status      (res_status),
        .out_granted     (res_granted),
        .out_ref_count   (res_ref_count),
        .out_in_use      (res_in_use),
        .out_peak_in_use (res_peak_in_use),
        .out_failures    (res_failures)
    );

    // result beat packing
    assign m_tdata = {1'b0, res_failures, res_peak_in_use, res_in_use,
                      res_ref_count, res_granted, res_status};

`ifndef SYNTHESIS
    // a request is followed by its update cycle, never by another request
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken back to back");

    // a new result only appears after an update cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without update cycle");

    // an exhausted pool grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == rbp_pkg::STATUS_EXHAUSTED) |-> (m_tdata[24:3] == '0))
        else $error("exhausted result carries an entry");
`endif

endmodule

// File: hdl/rbp_ctrl.sv
// rbp_ctrl: two-state sequencer and result-valid flag for the buffer pool
// depends on rbp_pkg
module rbp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output rbp_pkg::ctrl_cmd_t cmd
);

    rbp_pkg::state_t state_reg;
    rbp_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    // result register can take a new beat
    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbp_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = rbp_pkg::S_EXEC;
                end
            end
            rbp_pkg::S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = rbp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rbp_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.exec_en = 1'b0;
        unique case (state_reg)
            rbp_pkg::S_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.rd_en = s_tvalid;
            end
            rbp_pkg::S_EXEC:
            begin
                cmd.exec_en = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        if (cmd.exec_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rbp_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// File: hdl/rbp_dp.sv
// rbp_dp: free stacks, reference count memory, pool counters and result register
// depends on rbp_pkg; driven by rbp_ctrl commands
module rbp_dp
#(
    parameter int NUM_ENTRIES = rbp_pkg::NUM_ENTRIES_DEF,
    parameter int REF_WIDTH   = rbp_pkg::REF_WIDTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rbp_pkg::ctrl_cmd_t                 cmd,
    input  logic [rbp_pkg::OP_W-1:0]           in_op,
    input  logic                               in_pool,
    input  logic [rbp_pkg::IDX_FIELD_W-1:0]    in_index,
    input  logic                               cfg_we,
    input  logic                               cfg_addr,
    input  logic [rbp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic [rbp_pkg::STATUS_W-1:0]       out_status,
    output logic [rbp_pkg::IDX_FIELD_W-1:0]    out_granted,
    output logic [rbp_pkg::REF_FIELD_W-1:0]    out_ref_count,
    output logic [rbp_pkg::CNT_FIELD_W-1:0]    out_in_use,
    output logic [rbp_pkg::CNT_FIELD_W-1:0]    out_peak_in_use,
    output logic [rbp_pkg::FAIL_W-1:0]         out_failures
);

    localparam int IDX_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;
    localparam int CMP_W  = (CNT_W > rbp_pkg::IDX_FIELD_W) ? CNT_W : rbp_pkg::IDX_FIELD_W;
    localparam int RST0   = (rbp_pkg::POOL0_RESET > NUM_ENTRIES) ? NUM_ENTRIES
                                                                  : rbp_pkg::POOL0_RESET;
    localparam int RST1   = (rbp_pkg::POOL1_RESET > NUM_ENTRIES) ? NUM_ENTRIES
                                                                  : rbp_pkg::POOL1_RESET;
    localparam logic [REF_WIDTH-1:0] REF_MAX = {REF_WIDTH{1'b1}};

    // per-pool state
    logic [CNT_W-1:0]              cfg_entries_reg [2];
    logic [CNT_W-1:0]              free_top_reg    [2];
    logic [CNT_W-1:0]              in_use_reg      [2];
    logic [CNT_W-1:0]              high_water_reg  [2];
    logic [rbp_pkg::FAIL_W-1:0]    fail_reg        [2];
    logic [NUM_ENTRIES-1:0]        stack_vld_reg   [2];
    logic [NUM_ENTRIES-1:0]        ref_vld_reg     [2];

    // memories, both pools side by side, pool in the top address bit
    logic [IDX_W-1:0]              stack_mem [DEPTH];
    logic [REF_WIDTH-1:0]          ref_mem   [DEPTH];

    // read stage registers
    logic [rbp_pkg::OP_W-1:0]        op_reg;
    logic                            pool_reg;
    logic [rbp_pkg::IDX_FIELD_W-1:0] index_reg;
    logic [IDX_W-1:0]                pos_reg;
    logic [IDX_W-1:0]                stack_rd_reg;
    logic                            stack_hit_reg;
    logic [REF_WIDTH-1:0]            ref_rd_reg;
    logic                            ref_hit_reg;

    // result registers
    logic [rbp_pkg::STATUS_W-1:0]    status_reg;
    logic [rbp_pkg::IDX_FIELD_W-1:0] granted_reg;
    logic [rbp_pkg::REF_FIELD_W-1:0] ref_count_reg;
    logic [rbp_pkg::CNT_FIELD_W-1:0] in_use_out_reg;
    logic [rbp_pkg::CNT_FIELD_W-1:0] max_out_reg;
    logic [rbp_pkg::FAIL_W-1:0]      fail_out_reg;

    // read addresses
    logic [CNT_W-1:0] rd_top;
    logic [IDX_W-1:0] rd_pos;
    logic [IDX_W-1:0] rd_idx;

    // execute stage signals
    logic [CNT_W-1:0]                top;
    logic [CNT_W-1:0]                in_use;
    logic [CNT_W-1:0]                high_water;
    logic [rbp_pkg::FAIL_W-1:0]      fail;
    logic [CNT_W-1:0]                top_next;
    logic [CNT_W-1:0]                in_use_next;
    logic [CNT_W-1:0]                high_water_next;
    logic [rbp_pkg::FAIL_W-1:0]      fail_next;
    rbp_pkg::status_t                status_next;
    logic [rbp_pkg::IDX_FIELD_W-1:0] granted_next;
    logic [REF_WIDTH-1:0]            count_next;
    logic [REF_WIDTH-1:0]            cur_ref;
    logic [IDX_W-1:0]                pop_idx;
    logic [IDX_W-1:0]                entry_idx;
    logic                            in_range;
    logic                            stack_we;
    logic [IDX_W-1:0]                stack_wpos;
    logic [IDX_W-1:0]                stack_wdata;
    logic                            ref_we;
    logic [IDX_W-1:0]                ref_wpos;
    logic [REF_WIDTH-1:0]            ref_wdata;

    // configuration clamp
    logic [31:0]      cfg_wide;
    logic [CNT_W-1:0] cfg_clamped;

    // read addresses from the incoming beat
    assign rd_top = free_top_reg[in_pool];
    assign rd_pos = IDX_W'(rd_top - 1'b1);
    assign rd_idx = IDX_W'(in_index);

    // read stage: capture request and registered memory reads
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            op_reg        <= in_op;
            pool_reg      <= in_pool;
            index_reg     <= in_index;
            pos_reg       <= rd_pos;
            stack_rd_reg  <= stack_mem[{in_pool, rd_pos}];
            stack_hit_reg <= stack_vld_reg[in_pool][rd_pos];
            ref_rd_reg    <= ref_mem[{in_pool, rd_idx}];
            ref_hit_reg   <= ref_vld_reg[in_pool][rd_idx];
        end
    end

    // execute stage: decide the operation
    always_comb
    begin
        top             = free_top_reg[pool_reg];
        in_use          = in_use_reg[pool_reg];
        high_water      = high_water_reg[pool_reg];
        fail            = fail_reg[pool_reg];
        top_next        = top;
        in_use_next     = in_use;
        high_water_next = high_water;
        fail_next       = fail;
        status_next     = rbp_pkg::STATUS_OK;
        granted_next    = '0;
        count_next      = '0;
        // entries never written since the pool was set up read as fresh
        cur_ref         = ref_hit_reg ? ref_rd_reg : '0;
        pop_idx         = stack_hit_reg ? stack_rd_reg : pos_reg;
        entry_idx       = IDX_W'(index_reg);
        in_range        = (CMP_W'(index_reg) < CMP_W'(cfg_entries_reg[pool_reg]))
                          && (CMP_W'(index_reg) < CMP_W'(NUM_ENTRIES));
        stack_we        = 1'b0;
        stack_wpos      = IDX_W'(top);
        stack_wdata     = entry_idx;
        ref_we          = 1'b0;
        ref_wpos        = entry_idx;
        ref_wdata       = '0;
        unique case (op_reg)
            rbp_pkg::OP_ALLOC:
            begin
                if (top == '0 || top > CNT_W'(NUM_ENTRIES))
                begin
                    status_next = rbp_pkg::STATUS_EXHAUSTED;
                    if (fail != '1)
                    begin
                        fail_next = fail + 1'b1;
                    end
                end
                else
                begin
                    top_next     = top - 1'b1;
                    granted_next = rbp_pkg::IDX_FIELD_W'(pop_idx);
                    ref_we       = 1'b1;
                    ref_wpos     = pop_idx;
                    ref_wdata    = REF_WIDTH'(1);
                    count_next   = REF_WIDTH'(1);
                    in_use_next  = in_use + 1'b1;
                    if (in_use_next > high_water)
                    begin
                        high_water_next = in_use_next;
                    end
                end
            end
            rbp_pkg::OP_TAKE:
            begin
                granted_next = index_reg;
                if (!in_range || cur_ref == '0)
                begin
                    status_next = rbp_pkg::STATUS_INVALID;
                end
                else if (cur_ref == REF_MAX)
                begin
                    status_next = rbp_pkg::STATUS_SATURATED;
                    count_next  = cur_ref;
                end
                else
                begin
                    count_next = cur_ref + 1'b1;
                    ref_we     = 1'b1;
                    ref_wdata  = count_next;
                end
            end
            rbp_pkg::OP_RELEASE:
            begin
                granted_next = index_reg;
                if (!in_range || cur_ref == '0)
                begin
                    status_next = rbp_pkg::STATUS_INVALID;
                end
                else
                begin
                    count_next = cur_ref - 1'b1;
                    ref_we     = 1'b1;
                    ref_wdata  = count_next;
                    // last reference gone: push the entry back
                    if (count_next == '0)
                    begin
                        status_next = rbp_pkg::STATUS_FREED;
                        if (top < CNT_W'(NUM_ENTRIES))
                        begin
                            stack_we = 1'b1;
                            top_next = top + 1'b1;
                        end
                        if (in_use != '0)
                        begin
                            in_use_next = in_use - 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                status_next = rbp_pkg::STATUS_INVALID;
            end
        endcase
    end

    // clamp a written entry count to 1..NUM_ENTRIES
    always_comb
    begin
        cfg_wide = 32'(cfg_wdata);
        if (cfg_wide == 32'd0)
        begin
            cfg_wide = 32'd1;
        end
        else if (cfg_wide > 32'(NUM_ENTRIES))
        begin
            cfg_wide = 32'(NUM_ENTRIES);
        end
        cfg_clamped = CNT_W'(cfg_wide);
    end

    // pool counters and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_entries_reg[0] <= CNT_W'(RST0);
            cfg_entries_reg[1] <= CNT_W'(RST1);
            free_top_reg[0]    <= CNT_W'(RST0);
            free_top_reg[1]    <= CNT_W'(RST1);
            in_use_reg[0]      <= '0;
            in_use_reg[1]      <= '0;
            high_water_reg[0]  <= '0;
            high_water_reg[1]  <= '0;
            fail_reg[0]        <= '0;
            fail_reg[1]        <= '0;
            stack_vld_reg[0]   <= '0;
            stack_vld_reg[1]   <= '0;
            ref_vld_reg[0]     <= '0;
            ref_vld_reg[1]     <= '0;
        end
        else if (cfg_we)
        begin
            // rewrite of a pool size sets that pool up afresh, but keeps its peak and failure counts
            cfg_entries_reg[cfg_addr] <= cfg_clamped;
            free_top_reg[cfg_addr]    <= cfg_clamped;
            in_use_reg[cfg_addr]      <= '0;
            stack_vld_reg[cfg_addr]   <= '0;
            ref_vld_reg[cfg_addr]     <= '0;
        end
        else if (cmd.exec_en)
        begin
            free_top_reg[pool_reg]   <= top_next;
            in_use_reg[pool_reg]     <= in_use_next;
            high_water_reg[pool_reg] <= high_water_next;
            fail_reg[pool_reg]       <= fail_next;
            if (stack_we)
            begin
                stack_vld_reg[pool_reg][stack_wpos] <= 1'b1;
            end
            if (ref_we)
            begin
                ref_vld_reg[pool_reg][ref_wpos] <= 1'b1;
            end
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (cmd.exec_en && stack_we)
        begin
            stack_mem[{pool_reg, stack_wpos}] <= stack_wdata;
        end
        if (cmd.exec_en && ref_we)
        begin
            ref_mem[{pool_reg, ref_wpos}] <= ref_wdata;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.exec_en)
        begin
            status_reg     <= status_next;
            granted_reg    <= granted_next;
            ref_count_reg  <= rbp_pkg::REF_FIELD_W'(count_next);
            in_use_out_reg <= rbp_pkg::CNT_FIELD_W'(in_use_next);
            max_out_reg    <= rbp_pkg::CNT_FIELD_W'(high_water_next);
            fail_out_reg   <= fail_next;
        end
    end

    assign out_status      = status_reg;
    assign out_granted     = granted_reg;
    assign out_ref_count   = ref_count_reg;
    assign out_in_use      = in_use_out_reg;
    assign out_peak_in_use = max_out_reg;
    assign out_failures    = fail_out_reg;

endmodule
